/* rtl/tswr_pkg.sv */
package tswr_pkg;

   localparam int MAX_PAYLOAD     = 1000;
   localparam int STREAM_CAPACITY = 65536;
   localparam int QUEUE_DEPTH     = 64;
   localparam int OUT_MAX         = 64;

   localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int RIDX_W  = $clog2(OUT_MAX);
   localparam int RCNT_W  = $clog2(OUT_MAX + 1);
   localparam int BUF_W   = $clog2(STREAM_CAPACITY + 1);
   localparam int SEQLEN_W = 11;

   localparam logic [0:0] CSR_INITIAL_SEQ = 1'b0;
   localparam logic [0:0] CSR_INITIAL_RTO = 1'b1;

   typedef enum logic [1:0] {
      MODE_FILL  = 2'd0,
      MODE_ACK   = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_EMPTY = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_FILL_CHK,
      ST_FILL_SEND,
      ST_ACK_UNWRAP,
      ST_ACK_CMP,
      ST_POP_RD,
      ST_POP_CHK,
      ST_ACK_END,
      ST_TICK_ADD,
      ST_TICK_CHK,
      ST_TICK_RD,
      ST_TICK_EMIT,
      ST_EMPTY,
      ST_OUT_RD,
      ST_OUT_SHOW
   } state_type;

   typedef struct packed {
      logic [63:0]         start;
      logic [SEQLEN_W-1:0] len;
      logic                syn;
      logic                fin;
   } qent_type;

   typedef struct packed {
      logic        retx;
      logic        fin;
      logic        syn;
      logic [9:0]  len;
      logic [31:0] seqno;
   } rent_type;

endpackage

/* rtl/tcp_sender_window_retransmit_core.sv */
// TCP sender core: keeps sequence state, the peer window, a 64-entry queue of outstanding
// segments and the retransmit timer. Each request beat is one event (fill, ack, tick,
// empty segment) and produces 1 to 64 response beats, the final one flagged by rsp_last.
// Events are handled one at a time by a small sequencer: IDLE accepts the beat and PREP
// takes in the application bytes; fill then alternates a check and a send state per
// segment sent plus one closing check; ack unwraps and compares, reads and checks each
// queue entry examined, runs the fill steps and a closing state; tick adds the elapsed
// time, checks the timer and, if due, reads and re-emits the oldest segment; ST_EMPTY
// writes an empty one. A response beat reads the result buffer, then awaits rsp_ready.
// req_ready is low until the last response beat of the current event has been taken.
// CSR writes are accepted only while the core is idle.
module tcp_sender_window_retransmit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_ack_seq,
   input  logic [15:0] req_peer_window,
   input  logic [15:0] req_elapsed_ms,
   input  logic [15:0] req_bytes_added,
   input  logic        req_stream_ended,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_seg_valid,
   output logic [31:0] rsp_seg_seqno,
   output logic [9:0]  rsp_payload_len,
   output logic        rsp_syn_flag,
   output logic        rsp_fin_flag,
   output logic        rsp_is_retransmit,
   output logic        rsp_ack_accepted,
   output logic [7:0]  rsp_retx_count,
   output logic [16:0] rsp_in_flight,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int QW = tswr_pkg::QIDX_W;
   localparam int QC = tswr_pkg::QCNT_W;
   localparam int RI = tswr_pkg::RIDX_W;
   localparam int RC = tswr_pkg::RCNT_W;
   localparam int BW = tswr_pkg::BUF_W;
   localparam int SW = tswr_pkg::SEQLEN_W;

   tswr_pkg::state_type state_ff, state_in;

   logic [31:0] init_seq_ff;
   logic [15:0] init_rto_ff;

   tswr_pkg::mode_type mode_ff;
   logic [31:0] ack_w_ff;
   logic [15:0] pwin_ff, el_ff, add_ff;
   logic        ended_ff;

   logic        syn_sent_ff, fin_sent_ff, timer_on_ff, closed_ff, accepted_ff;
   logic [63:0] next_ff, acked_ff, abs_ff;
   logic [15:0] window_ff, room_ff;
   logic [16:0] flight_ff;
   logic [31:0] timer_ff, rto_ff;
   logic [7:0]  retx_ff;
   logic [BW-1:0] buf_ff;
   logic [QW-1:0] head_ff;
   logic [QC-1:0] qcnt_ff;
   logic [RC-1:0] nres_ff, oidx_ff;

   tswr_pkg::qent_type qmem [tswr_pkg::QUEUE_DEPTH];
   tswr_pkg::qent_type q_rd_ff, q_wdata;
   logic               q_we;
   logic [QW-1:0]      q_waddr;

   tswr_pkg::rent_type rmem [tswr_pkg::OUT_MAX];
   tswr_pkg::rent_type r_rd_ff, r_wdata;
   logic               r_we;

   logic        q_full, r_full, fill_ret_ack;
   logic [15:0] win;
   logic [63:0] used;
   logic        used_ge;
   logic [9:0]  f_len;
   logic [BW-1:0] f_newbuf;
   logic        f_fin, f_stop;
   logic [SW-1:0] f_seqlen;
   logic [31:0] off, lo_diff;
   logic [63:0] unwrap;
   logic [63:0] q_end;
   logic [32:0] timer_sum;
   logic [BW-1:0] freecap;
   logic [BW-1:0] add_cut;
   logic [31:0] rto_dbl;

   assign q_full = (qcnt_ff == QC'(tswr_pkg::QUEUE_DEPTH));
   assign r_full = (nres_ff == RC'(tswr_pkg::OUT_MAX));
   assign fill_ret_ack = (mode_ff == tswr_pkg::MODE_ACK);
   assign win = (window_ff != 16'd0) ? window_ff : 16'd1;
   assign used = next_ff - acked_ff;
   assign used_ge = (used[63:16] != 48'd0) || (used[15:0] >= win);

   always_comb begin
      logic [15:0] m;
      m = (room_ff < 16'(tswr_pkg::MAX_PAYLOAD)) ? room_ff : 16'(tswr_pkg::MAX_PAYLOAD);
      if (BW'(m) > buf_ff) begin
         m = 16'(buf_ff);
      end
      f_len = m[9:0];
      f_newbuf = buf_ff - BW'(m);
      f_fin = closed_ff && (f_newbuf == BW'(0)) && (m < room_ff);
      f_stop = (m == 16'd0) && !f_fin;
      f_seqlen = SW'(f_len) + SW'(f_fin);
   end

   always_comb begin
      logic [63:0] c;
      off = ack_w_ff - init_seq_ff;
      lo_diff = off - acked_ff[31:0];
      c = {acked_ff[63:32], off};
      if (off > acked_ff[31:0]) begin
         if (lo_diff > 32'h8000_0000 && acked_ff[63:32] != 32'd0) begin
            c = {acked_ff[63:32] - 32'd1, off};
         end
      end else begin
         if ((acked_ff[31:0] - off) > 32'h8000_0000) begin
            c = {acked_ff[63:32] + 32'd1, off};
         end
      end
      unwrap = c;
   end

   assign q_end = q_rd_ff.start + 64'(q_rd_ff.len);
   assign timer_sum = {1'b0, timer_ff} + 33'(el_ff);
   assign freecap = BW'(tswr_pkg::STREAM_CAPACITY) - buf_ff;
   assign add_cut = (BW'(add_ff) < freecap) ? BW'(add_ff) : freecap;
   assign rto_dbl = (rto_ff > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {rto_ff[30:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tswr_pkg::ST_IDLE: begin
            if (req_valid) state_in = tswr_pkg::ST_PREP;
         end
         tswr_pkg::ST_PREP: begin
            unique case (mode_ff)
               tswr_pkg::MODE_FILL:  state_in = tswr_pkg::ST_FILL_CHK;
               tswr_pkg::MODE_ACK:   state_in = tswr_pkg::ST_ACK_UNWRAP;
               tswr_pkg::MODE_TICK:  state_in = tswr_pkg::ST_TICK_ADD;
               tswr_pkg::MODE_EMPTY: state_in = tswr_pkg::ST_EMPTY;
               default:              state_in = tswr_pkg::ST_EMPTY;
            endcase
         end
         tswr_pkg::ST_FILL_CHK: begin
            if (!syn_sent_ff || fin_sent_ff || q_full || r_full || used_ge) begin
               state_in = fill_ret_ack ? tswr_pkg::ST_ACK_END : tswr_pkg::ST_OUT_RD;
            end else begin
               state_in = tswr_pkg::ST_FILL_SEND;
            end
         end
         tswr_pkg::ST_FILL_SEND: begin
            if (f_stop) begin
               state_in = fill_ret_ack ? tswr_pkg::ST_ACK_END : tswr_pkg::ST_OUT_RD;
            end else begin
               state_in = tswr_pkg::ST_FILL_CHK;
            end
         end
         tswr_pkg::ST_ACK_UNWRAP: state_in = tswr_pkg::ST_ACK_CMP;
         tswr_pkg::ST_ACK_CMP: begin
            if (abs_ff > next_ff || abs_ff <= acked_ff) state_in = tswr_pkg::ST_OUT_RD;
            else state_in = tswr_pkg::ST_POP_RD;
         end
         tswr_pkg::ST_POP_RD: begin
            if (qcnt_ff == QC'(0)) state_in = tswr_pkg::ST_FILL_CHK;
            else state_in = tswr_pkg::ST_POP_CHK;
         end
         tswr_pkg::ST_POP_CHK: begin
            if (q_end > abs_ff) state_in = tswr_pkg::ST_FILL_CHK;
            else state_in = tswr_pkg::ST_POP_RD;
         end
         tswr_pkg::ST_ACK_END: state_in = tswr_pkg::ST_OUT_RD;
         tswr_pkg::ST_TICK_ADD: state_in = tswr_pkg::ST_TICK_CHK;
         tswr_pkg::ST_TICK_CHK: begin
            if (timer_ff >= rto_ff && qcnt_ff != QC'(0)) state_in = tswr_pkg::ST_TICK_RD;
            else state_in = tswr_pkg::ST_OUT_RD;
         end
         tswr_pkg::ST_TICK_RD: state_in = tswr_pkg::ST_TICK_EMIT;
         tswr_pkg::ST_TICK_EMIT: state_in = tswr_pkg::ST_OUT_RD;
         tswr_pkg::ST_EMPTY: state_in = tswr_pkg::ST_OUT_RD;
         tswr_pkg::ST_OUT_RD: state_in = tswr_pkg::ST_OUT_SHOW;
         tswr_pkg::ST_OUT_SHOW: begin
            if (rsp_ready) begin
               if (oidx_ff + RC'(1) >= nres_ff) state_in = tswr_pkg::ST_IDLE;
               else state_in = tswr_pkg::ST_OUT_RD;
            end
         end
         default: state_in = tswr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == tswr_pkg::ST_IDLE);
      csr_ready = (state_ff == tswr_pkg::ST_IDLE);
      rsp_valid = (state_ff == tswr_pkg::ST_OUT_SHOW);
      q_we = 1'b0;
      q_waddr = head_ff + qcnt_ff[QW-1:0];
      q_wdata = '{start: next_ff, len: f_seqlen, syn: 1'b0, fin: f_fin};
      r_we = 1'b0;
      r_wdata = '{retx: 1'b0, fin: f_fin, syn: 1'b0, len: f_len,
                  seqno: next_ff[31:0] + init_seq_ff};
      unique case (state_ff)
         tswr_pkg::ST_FILL_CHK: begin
            if (!syn_sent_ff && !q_full && !r_full) begin
               q_we = 1'b1;
               r_we = 1'b1;
               q_wdata = '{start: next_ff, len: SW'(1), syn: 1'b1, fin: 1'b0};
               r_wdata = '{retx: 1'b0, fin: 1'b0, syn: 1'b1, len: 10'd0,
                           seqno: next_ff[31:0] + init_seq_ff};
            end
         end
         tswr_pkg::ST_FILL_SEND: begin
            q_we = !f_stop;
            r_we = !f_stop;
         end
         tswr_pkg::ST_TICK_EMIT: begin
            r_we = 1'b1;
            r_wdata = '{retx: 1'b1, fin: q_rd_ff.fin, syn: q_rd_ff.syn,
                        len: 10'(q_rd_ff.len - SW'(q_rd_ff.syn) - SW'(q_rd_ff.fin)),
                        seqno: q_rd_ff.start[31:0] + init_seq_ff};
         end
         tswr_pkg::ST_EMPTY: begin
            r_we = 1'b1;
            r_wdata = '{retx: 1'b0, fin: 1'b0, syn: 1'b0, len: 10'd0,
                        seqno: next_ff[31:0] + init_seq_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_we) qmem[q_waddr] <= q_wdata;
      q_rd_ff <= qmem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (r_we) rmem[nres_ff[RI-1:0]] <= r_wdata;
      r_rd_ff <= rmem[oidx_ff[RI-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= tswr_pkg::mode_type'(req_mode);
         ack_w_ff <= req_ack_seq;
         pwin_ff  <= req_peer_window;
         el_ff    <= req_elapsed_ms;
         add_ff   <= req_bytes_added;
         ended_ff <= req_stream_ended;
      end
      if (state_ff == tswr_pkg::ST_ACK_UNWRAP) abs_ff <= unwrap;
      if (state_ff == tswr_pkg::ST_FILL_CHK) room_ff <= win - used[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tswr_pkg::ST_IDLE;
         init_seq_ff <= 32'd0;
         init_rto_ff <= 16'd1000;
         syn_sent_ff <= 1'b0;
         fin_sent_ff <= 1'b0;
         timer_on_ff <= 1'b0;
         closed_ff   <= 1'b0;
         accepted_ff <= 1'b1;
         next_ff     <= 64'd0;
         acked_ff    <= 64'd0;
         window_ff   <= 16'd1;
         flight_ff   <= 17'd0;
         timer_ff    <= 32'd0;
         rto_ff      <= 32'd1000;
         retx_ff     <= 8'd0;
         buf_ff      <= '0;
         head_ff     <= '0;
         qcnt_ff     <= '0;
         nres_ff     <= '0;
         oidx_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (q_we) begin
            qcnt_ff   <= qcnt_ff + QC'(1);
            next_ff   <= next_ff + 64'(q_wdata.len);
            flight_ff <= flight_ff + 17'(q_wdata.len);
            if (!timer_on_ff) begin
               timer_on_ff <= 1'b1;
               timer_ff    <= 32'd0;
            end
         end
         if (r_we) nres_ff <= nres_ff + RC'(1);
         unique case (state_ff)
            tswr_pkg::ST_IDLE: begin
               if (req_valid) begin
                  nres_ff     <= '0;
                  oidx_ff     <= '0;
                  accepted_ff <= 1'b1;
               end
            end
            tswr_pkg::ST_PREP: begin
               buf_ff <= buf_ff + add_cut;
               if (ended_ff) closed_ff <= 1'b1;
            end
            tswr_pkg::ST_FILL_CHK: begin
               if (!syn_sent_ff && !q_full && !r_full) syn_sent_ff <= 1'b1;
            end
            tswr_pkg::ST_FILL_SEND: begin
               buf_ff <= f_newbuf;
               if (f_fin) fin_sent_ff <= 1'b1;
            end
            tswr_pkg::ST_ACK_CMP: begin
               if (abs_ff > next_ff) begin
                  accepted_ff <= 1'b0;
               end else begin
                  window_ff <= pwin_ff;
                  if (abs_ff > acked_ff) acked_ff <= abs_ff;
               end
            end
            tswr_pkg::ST_POP_CHK: begin
               if (!(q_end > abs_ff)) begin
                  flight_ff <= (flight_ff >= 17'(q_rd_ff.len)) ?
                               flight_ff - 17'(q_rd_ff.len) : 17'd0;
                  head_ff   <= head_ff + QW'(1);
                  qcnt_ff   <= qcnt_ff - QC'(1);
               end
            end
            tswr_pkg::ST_ACK_END: begin
               rto_ff  <= 32'(init_rto_ff);
               retx_ff <= 8'd0;
               if (qcnt_ff != QC'(0)) begin
                  timer_on_ff <= 1'b1;
                  timer_ff    <= 32'd0;
               end
            end
            tswr_pkg::ST_TICK_ADD: begin
               timer_ff <= timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
            end
            tswr_pkg::ST_TICK_CHK: begin
               if (qcnt_ff == QC'(0)) timer_on_ff <= 1'b0;
            end
            tswr_pkg::ST_TICK_EMIT: begin
               if (retx_ff != 8'hFF) retx_ff <= retx_ff + 8'd1;
               if (window_ff != 16'd0) rto_ff <= rto_dbl;
               else if (next_ff != 64'(flight_ff)) rto_ff <= 32'(init_rto_ff);
               else rto_ff <= rto_dbl;
               timer_on_ff <= 1'b1;
               timer_ff    <= 32'd0;
            end
            tswr_pkg::ST_OUT_SHOW: begin
               if (rsp_ready) oidx_ff <= oidx_ff + RC'(1);
            end
            default: begin
            end
         endcase
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tswr_pkg::CSR_INITIAL_SEQ: init_seq_ff <= csr_data;
               tswr_pkg::CSR_INITIAL_RTO: begin
                  init_rto_ff <= csr_data[15:0];
                  rto_ff      <= 32'(csr_data[15:0]);
               end
               default: begin
               end
            endcase
         end
      end
   end

   logic has_res;
   assign has_res = (nres_ff != RC'(0));

   assign rsp_seg_valid     = has_res;
   assign rsp_seg_seqno     = has_res ? r_rd_ff.seqno : 32'd0;
   assign rsp_payload_len   = has_res ? r_rd_ff.len : 10'd0;
   assign rsp_syn_flag      = has_res && r_rd_ff.syn;
   assign rsp_fin_flag      = has_res && r_rd_ff.fin;
   assign rsp_is_retransmit = has_res && r_rd_ff.retx;
   assign rsp_ack_accepted  = accepted_ff;
   assign rsp_retx_count    = retx_ff;
   assign rsp_in_flight     = flight_ff;
   assign rsp_last          = (oidx_ff + RC'(1) >= nres_ff);

endmodule
